// ----- hdl/gbrbm_pkg.sv -----
// Package for the Gaussian-Bernoulli RBM conditional engine.
// Holds sizes, operation codes and the sigmoid approximation.
// No dependencies.
package gbrbm_pkg;

    localparam int MaxVisible = 256;
    localparam int MaxHidden  = 256;
    localparam int VisW = $clog2(MaxVisible);
    localparam int HidW = $clog2(MaxHidden);
    localparam int CntW = 9;

    typedef enum logic [2:0] {
        OP_WEIGHT   = 3'd0,
        OP_HBIAS    = 3'd1,
        OP_VBIAS    = 3'd2,
        OP_INVVAR   = 3'd3,
        OP_VNODE    = 3'd4,
        OP_HNODE    = 3'd5,
        OP_HQUERY   = 3'd6,
        OP_VQUERY   = 3'd7
    } t_op;

    localparam logic [0:0] RegVisibleCount = 1'b0;
    localparam logic [0:0] RegHiddenCount  = 1'b1;

    // Piecewise-linear sigmoid, Q15.16 in, Q0.16 out, capped at 65535.
    function automatic logic [31:0] sigmoid_q16(input logic signed [31:0] x);
        logic [32:0] a;
        logic [32:0] y;
        begin
            a = x[31] ? (33'd0 - {x[31], x}) : {1'b0, x};
            if (a >= 33'd327680) y = 33'd65536;
            else if (a >= 33'd155648) y = (a >> 5) + 33'd55296;
            else if (a >= 33'd65536) y = (a >> 3) + 33'd40960;
            else y = (a >> 2) + 33'd32768;
            if (x[31]) y = 33'd65536 - y;
            if (y > 33'd65535) y = 33'd65535;
            sigmoid_q16 = y[31:0];
        end
    endfunction

endpackage

// ----- hdl/gbrbm_conditional_engine_core.sv -----
// Top level of the Gaussian-Bernoulli RBM conditional engine.
// A load is written to its memory when it is accepted. A query runs the head, MAC, round,
// divider and output states; the MAC does one multiply-accumulate per cycle over the weight
// memory read port, and a visible query on a nonzero inverse variance then runs a 48-step
// restoring divider. One item is in work at a time; the result sits in an output register.
// Reset (synchronous, active low) sets both counts to 256; memories are not cleared.
// Uses gbrbm_pkg.
module gbrbm_conditional_engine_core
    import gbrbm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] op, [10:3] vis_index, [18:11] hid_index, [34:19] value, zero fill
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] field_sum, [63:32] derived, [64] status, zero fill
    output logic [71:0] m_axis_tdata
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_HEAD  = 6'b000010,
        ST_MAC   = 6'b000100,
        ST_ROUND = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

    // Memories.
    logic signed [15:0] mem_w  [MaxVisible*MaxHidden];
    logic signed [15:0] mem_vb [MaxVisible];
    logic signed [15:0] mem_hb [MaxHidden];
    logic signed [15:0] mem_iv [MaxVisible];
    logic signed [15:0] mem_vn [MaxVisible];
    logic signed [15:0] mem_hn [MaxHidden];

    logic [CntW-1:0] r_vis_count, r_hid_count;
    t_state r_state;
    logic r_is_hid;
    logic [VisW-1:0] r_vi;
    logic [HidW-1:0] r_hi;
    logic [CntW-1:0] r_k, r_n;
    logic r_rd_valid;
    logic signed [15:0] r_rd_w, r_rd_node, r_rd_bias, r_rd_iv;
    logic signed [31:0] r_prod;
    logic r_prod_valid;
    logic signed [47:0] r_acc;
    logic signed [31:0] r_sum;
    logic r_out_valid;
    logic [71:0] r_out;
    // Divider state.
    logic [5:0] r_div_step;
    logic [47:0] r_quo, r_rem;
    logic [15:0] r_div_den;
    logic r_neg;

    t_op in_op;
    logic [VisW-1:0] in_vi;
    logic [HidW-1:0] in_hi;
    logic signed [15:0] in_val;
    logic in_fire;
    assign in_op  = t_op'(s_axis_tdata[2:0]);
    assign in_vi  = s_axis_tdata[10:3];
    assign in_hi  = s_axis_tdata[18:11];
    assign in_val = s_axis_tdata[34:19];
    assign s_axis_tready = (r_state == ST_IDLE) && !r_out_valid;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = r_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vis_count <= CntW'(MaxVisible);
            r_hid_count <= CntW'(MaxHidden);
        end else if (i_cfg_we) begin
            if (i_cfg_index == RegVisibleCount) r_vis_count <= i_cfg_data;
            else r_hid_count <= i_cfg_data;
        end
    end

    // Write side of the memories.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            case (in_op)
                OP_WEIGHT: mem_w[{in_vi, in_hi}] <= in_val;
                OP_HBIAS:  mem_hb[in_hi] <= in_val;
                OP_VBIAS:  mem_vb[in_vi] <= in_val;
                OP_INVVAR: mem_iv[in_vi] <= in_val;
                OP_VNODE:  mem_vn[in_vi] <= in_val;
                OP_HNODE:  mem_hn[in_hi] <= in_val;
                default: ;
            endcase
        end
    end

    // Read side: one weight and one node per cycle, bias and variance from the query's fixed index.
    logic [VisW-1:0] rd_vi;
    logic [HidW-1:0] rd_hi;
    assign rd_vi = r_is_hid ? r_k[VisW-1:0] : r_vi;
    assign rd_hi = r_is_hid ? r_hi : r_k[HidW-1:0];
    always_ff @(posedge i_clk) begin
        r_rd_w    <= mem_w[{rd_vi, rd_hi}];
        r_rd_node <= r_is_hid ? mem_vn[r_k[VisW-1:0]] : mem_hn[r_k[HidW-1:0]];
        r_rd_bias <= r_is_hid ? mem_hb[r_hi] : mem_vb[r_vi];
        r_rd_iv   <= mem_iv[r_vi];
    end

    // Rounding and saturation of the Q.24 accumulator.
    logic signed [47:0] acc_rnd;
    logic signed [39:0] acc_sh;
    logic signed [31:0] sum_sat;
    always_comb begin
        acc_rnd = r_acc + 48'sd128;
        acc_sh = acc_rnd[47:8];
        if (acc_sh > 40'sd2147483647) sum_sat = 32'sh7FFFFFFF;
        else if (acc_sh < -40'sd2147483648) sum_sat = 32'sh80000000;
        else sum_sat = acc_sh[31:0];
    end

    // Divider step and final quotient.
    logic [48:0] rem_try;
    logic [47:0] quo_sat;
    logic signed [31:0] div_res;
    always_comb begin
        rem_try = {r_rem[47:0], r_quo[47]} - {33'd0, r_div_den};
        quo_sat = r_quo;
        if (!r_neg && r_quo > 48'd2147483647) div_res = 32'sh7FFFFFFF;
        else if (r_neg && r_quo > 48'd2147483648) div_res = 32'sh80000000;
        else div_res = r_neg ? 32'(-quo_sat) : quo_sat[31:0];
    end

    logic signed [47:0] num_abs;
    logic [15:0] den_abs;
    assign num_abs = r_sum[31] ? -({{16{r_sum[31]}}, r_sum} <<< 12)
                               : ({{16{r_sum[31]}}, r_sum} <<< 12);
    assign den_abs = r_rd_iv[15] ? 16'(-r_rd_iv) : r_rd_iv;

    // Main sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_rd_valid <= 1'b0;
            r_prod_valid <= 1'b0;
            r_is_hid <= 1'b0;
            r_k <= '0;
        end else begin
            if (r_out_valid && m_axis_tready) r_out_valid <= 1'b0;
            r_prod <= r_rd_w * r_rd_node;
            r_prod_valid <= r_rd_valid;
            case (r_state)
                ST_IDLE: begin
                    if (in_fire && (in_op == OP_HQUERY || in_op == OP_VQUERY)) begin
                        r_is_hid <= (in_op == OP_HQUERY);
                        r_vi <= in_vi;
                        r_hi <= in_hi;
                        r_k <= '0;
                        r_n <= (in_op == OP_HQUERY) ?
                               ((r_vis_count > CntW'(MaxVisible)) ? CntW'(MaxVisible)
                                                                   : r_vis_count) :
                               ((r_hid_count > CntW'(MaxHidden)) ? CntW'(MaxHidden)
                                                                  : r_hid_count);
                        r_state <= ST_HEAD;
                    end
                end
                ST_HEAD: begin
                    // The bias is addressed this cycle and lands in the first MAC cycle.
                    r_state <= ST_MAC;
                    r_rd_valid <= 1'b0;
                end
                ST_MAC: begin
                    if (r_k < r_n) begin
                        r_rd_valid <= 1'b1;
                        r_k <= r_k + 1'b1;
                    end else begin
                        r_rd_valid <= 1'b0;
                    end
                    // The first MAC cycle seeds the sum with the bias; no product is ready yet.
                    if (r_k == '0) r_acc <= 48'(r_rd_bias) <<< 12;
                    else if (r_prod_valid) r_acc <= r_acc + 48'(r_prod);
                    if (r_k >= r_n && !r_rd_valid && !r_prod_valid)
                        r_state <= ST_ROUND;
                end
                ST_ROUND: begin
                    r_sum <= sum_sat;
                    r_state <= ST_DIV;
                    r_div_step <= '0;
                end
                ST_DIV: begin
                    if (r_is_hid) begin
                        r_out <= {7'd0, 1'b0, sigmoid_q16(r_sum), r_sum};
                        r_state <= ST_OUT;
                    end else if (r_rd_iv == 16'sd0) begin
                        r_out <= {7'd0, 1'b1, 32'd0, r_sum};
                        r_state <= ST_OUT;
                    end else if (r_div_step == 6'd0) begin
                        r_quo <= num_abs;
                        r_rem <= '0;
                        r_div_den <= den_abs;
                        r_neg <= r_sum[31] ^ r_rd_iv[15];
                        r_div_step <= 6'd1;
                    end else if (r_div_step <= 6'd48) begin
                        if (!rem_try[48]) begin
                            r_rem <= rem_try[47:0];
                            r_quo <= {r_quo[46:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[46:0], r_quo[47]};
                            r_quo <= {r_quo[46:0], 1'b0};
                        end
                        r_div_step <= r_div_step + 1'b1;
                    end else begin
                        r_out <= {7'd0, 1'b0, div_res, r_sum};
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    r_out_valid <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- test/gbrbm_conditional_engine_core_test.sv -----
// Self-checking testbench for gbrbm_conditional_engine_core: loads RBM stores, runs both
// conditional queries under random stalls, checks results against a local predictor or typed row.
// Depends on gbrbm_pkg and the core module.
`timescale 1ns / 1ps

module gbrbm_conditional_engine_core_test;
    import gbrbm_pkg::*;

    typedef struct {
        t_op               op;
        logic [7:0]        vi;
        logic [7:0]        hi;
        logic signed [15:0] val;
        bit                typed;
        logic [31:0]       t_sum;
        logic [31:0]       t_der;
        logic              t_st;
    } t_req;

    typedef struct {
        logic [31:0] fsum;
        logic [31:0] der;
        logic        st;
    } t_result;

    localparam int WatchdogLimit = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = '0;
    logic [8:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [2:0] op, [10:3] vis_index, [18:11] hid_index, [34:19] value, zero fill
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [31:0] field_sum, [63:32] derived, [64] status, zero fill
    logic [71:0] m_axis_tdata;

    gbrbm_conditional_engine_core DUT (.*);

    always #6 i_clk = ~i_clk;

    // Predictor copy of the stores and the counts.
    logic signed [15:0] w_mem [0:65535];
    logic signed [15:0] vbias [0:255];
    logic signed [15:0] hbias [0:255];
    logic signed [15:0] ivar [0:255];
    logic signed [15:0] vnode [0:255];
    logic signed [15:0] hnode [0:255];
    int unsigned        vis_cnt = 256;
    int unsigned        hid_cnt = 256;

    // Which entries the stimulus has already written, known at generation time.
    bit w_ok [0:65535];
    bit vb_ok [0:255];
    bit hb_ok [0:255];
    bit iv_ok [0:255];
    bit vn_ok [0:255];
    bit hn_ok [0:255];
    int unsigned gen_vc = 256;
    int unsigned gen_hc = 256;

    t_req    reqs [$];
    t_result pending [$];
    int      errors = 0;
    int      n_loads = 0, n_hq = 0, n_vq = 0, n_flag = 0;
    int      idle_cycles = 0;

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // Q.24 accumulator to Q15.16, round half up, saturate.
    function automatic longint round_q16(longint acc);
        longint off;
        off = 64'sd1 << 52;
        return sat32((acc + 128 + off) / 256 - off / 256);
    endfunction

    function automatic longint approx_sigmoid(longint x);
        longint a, y;
        a = (x < 0) ? -x : x;
        if (a >= 327680) y = 65536;
        else if (a >= 155648) y = a / 32 + 55296;
        else if (a >= 65536) y = a / 8 + 40960;
        else y = a / 4 + 32768;
        if (x < 0) y = 65536 - y;
        if (y > 65535) y = 65535;
        return y;
    endfunction

    // Applies one accepted request to the predictor; queues the result of a query.
    task automatic apply_request(input t_req r);
        longint acc, fs, dv;
        int unsigned n;
        logic st;
        t_result res;
        acc = 0;
        dv = 0;
        st = 1'b0;
        case (r.op)
            OP_WEIGHT: w_mem[{r.vi, r.hi}] = r.val;
            OP_HBIAS:  hbias[r.hi] = r.val;
            OP_VBIAS:  vbias[r.vi] = r.val;
            OP_INVVAR: ivar[r.vi] = r.val;
            OP_VNODE:  vnode[r.vi] = r.val;
            OP_HNODE:  hnode[r.hi] = r.val;
            default: ;
        endcase
        if (r.op != OP_HQUERY && r.op != OP_VQUERY) begin
            n_loads++;
            return;
        end
        if (r.op == OP_HQUERY) begin
            n_hq++;
            acc = longint'(hbias[r.hi]) * 4096;
            n = (vis_cnt > MaxVisible) ? MaxVisible : vis_cnt;
            for (int k = 0; k < n; k++)
                acc += longint'(w_mem[{k[7:0], r.hi}]) * longint'(vnode[k]);
            fs = round_q16(acc);
            dv = approx_sigmoid(fs);
        end else begin
            n_vq++;
            acc = longint'(vbias[r.vi]) * 4096;
            n = (hid_cnt > MaxHidden) ? MaxHidden : hid_cnt;
            for (int k = 0; k < n; k++)
                acc += longint'(w_mem[{r.vi, k[7:0]}]) * longint'(hnode[k]);
            fs = round_q16(acc);
            if (ivar[r.vi] == 0) begin
                st = 1'b1;
                n_flag++;
            end else begin
                dv = sat32((fs * 4096) / longint'(ivar[r.vi]));
            end
        end
        res.fsum = fs[31:0];
        res.der = dv[31:0];
        res.st = st;
        if (r.typed && (res.fsum != r.t_sum || res.der != r.t_der || res.st != r.t_st)) begin
            $display("%0t predictor disagrees with typed row: op %s", $time, r.op.name());
        end
        if (r.typed) begin
            res.fsum = r.t_sum;
            res.der = r.t_der;
            res.st = r.t_st;
        end
        pending.push_back(res);
    endtask

    function automatic t_req mk(t_op op, int vi, int hi, int val);
        t_req r;
        r.op = op;
        r.vi = vi[7:0];
        r.hi = hi[7:0];
        r.val = val[15:0];
        r.typed = 1'b0;
        r.t_sum = '0;
        r.t_der = '0;
        r.t_st = 1'b0;
        return r;
    endfunction

    function automatic logic signed [15:0] rand_val();
        case ($urandom_range(0, 9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sd0;
            default: return 16'($urandom);
        endcase
    endfunction

    // Queues a load and records that the entry now holds a value.
    function automatic void add_load(t_op op, int vi, int hi);
        reqs.push_back(mk(op, vi, hi, rand_val()));
        case (op)
            OP_WEIGHT: w_ok[vi * 256 + hi] = 1'b1;
            OP_HBIAS:  hb_ok[hi] = 1'b1;
            OP_VBIAS:  vb_ok[vi] = 1'b1;
            OP_INVVAR: iv_ok[vi] = 1'b1;
            OP_VNODE:  vn_ok[vi] = 1'b1;
            OP_HNODE:  hn_ok[hi] = 1'b1;
            default: ;
        endcase
    endfunction

    // Queues a query, preceded by loads of every entry it reads that is still unwritten.
    function automatic void add_query(t_op op, int idx);
        int n;
        if (op == OP_HQUERY) begin
            n = (gen_vc > MaxVisible) ? MaxVisible : gen_vc;
            if (!hb_ok[idx]) add_load(OP_HBIAS, 0, idx);
            for (int k = 0; k < n; k++) begin
                if (!w_ok[k * 256 + idx]) add_load(OP_WEIGHT, k, idx);
                if (!vn_ok[k]) add_load(OP_VNODE, k, 0);
            end
        end else begin
            n = (gen_hc > MaxHidden) ? MaxHidden : gen_hc;
            if (!vb_ok[idx]) add_load(OP_VBIAS, idx, 0);
            if (!iv_ok[idx]) add_load(OP_INVVAR, idx, 0);
            for (int k = 0; k < n; k++) begin
                if (!w_ok[idx * 256 + k]) add_load(OP_WEIGHT, idx, k);
                if (!hn_ok[k]) add_load(OP_HNODE, 0, k);
            end
        end
        reqs.push_back(mk(op, idx, idx, $urandom));
    endfunction

    // Random traffic: mostly loads and queries inside a window of low indices.
    function automatic void gen_random(int items, int query_pct);
        int win, vi, hi;
        t_op op;
        win = (gen_vc > gen_hc ? gen_vc : gen_hc);
        win = (win > 16) ? 16 : win + 2;
        for (int i = 0; i < items; i++) begin
            vi = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, win - 1);
            hi = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, win - 1);
            if ($urandom_range(1, 100) <= query_pct) begin
                op = $urandom_range(0, 1) ? OP_HQUERY : OP_VQUERY;
                add_query(op, op == OP_HQUERY ? hi : vi);
            end else begin
                op = t_op'($urandom_range(0, 5));
                add_load(op, vi, hi);
            end
        end
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // Sends every queued request, then waits until the block is idle again.
    task automatic drive_all();
        t_req r;
        int gap;
        while (reqs.size() > 0) begin
            r = reqs.pop_front();
            gap = pick_gap();
            if (gap > 0 && s_axis_tvalid) s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= {5'd0, r.val, r.hi, r.vi, r.op};
            do @(posedge i_clk); while (!s_axis_tready);
            apply_request(r);
        end
        s_axis_tvalid <= 1'b0;
        while (pending.size() > 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    // Raises the write enable for one register; the caller drops it after the last write.
    task automatic write_reg(input logic [0:0] idx, input int unsigned data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data[8:0];
        @(posedge i_clk);
        if (idx == RegVisibleCount) vis_cnt = data;
        else hid_cnt = data;
        if (idx == RegVisibleCount) gen_vc = data;
        else gen_hc = data;
    endtask

    task automatic set_counts(input int unsigned vc, input int unsigned hc);
        write_reg(RegVisibleCount, vc);
        write_reg(RegHiddenCount, hc);
        i_cfg_we <= 1'b0;
    endtask

    function automatic void add_typed(t_req r, int s, int d, bit st);
        r.typed = 1'b1;
        r.t_sum = s;
        r.t_der = d;
        r.t_st = st;
        reqs.push_back(r);
    endfunction

    // Output side: ready in runs, with short and occasional long stalls.
    int rdy_left = 0;
    always @(posedge i_clk) begin
        if (rdy_left == 0) begin
            case ($urandom_range(0, 19))
                0:       begin m_axis_tready <= 1'b0; rdy_left = $urandom_range(20, 60); end
                1, 2, 3, 4, 5:
                         begin m_axis_tready <= 1'b0; rdy_left = $urandom_range(1, 4); end
                default: begin m_axis_tready <= 1'b1; rdy_left = $urandom_range(1, 20); end
            endcase
        end else begin
            rdy_left--;
        end
    end

    // Result checker against the oldest outstanding expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending.size() == 0) begin
                $display("%0t unexpected result: sum %h derived %h status %b", $time,
                         m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[64]);
                errors++;
            end else begin
                automatic t_result e = pending.pop_front();
                if (m_axis_tdata[31:0] !== e.fsum) begin
                    $display("%0t field_sum: expected %h, got %h", $time, e.fsum,
                             m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[63:32] !== e.der) begin
                    $display("%0t derived: expected %h, got %h", $time, e.der,
                             m_axis_tdata[63:32]);
                    errors++;
                end
                if (m_axis_tdata[64] !== e.st) begin
                    $display("%0t status: expected %b, got %b", $time, e.st, m_axis_tdata[64]);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted request or result.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("%0t watchdog expired, %0d results outstanding", $time, pending.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Directed table, run with both counts at zero so that sums are the bias alone.
    task automatic build_directed();
        reqs.push_back(mk(OP_WEIGHT, 0, 0, 16'h7fff));
        reqs.push_back(mk(OP_VNODE, 255, 0, 16'h8000));
        reqs.push_back(mk(OP_HNODE, 0, 255, 16'h5a5a));
        reqs.push_back(mk(OP_HBIAS, 0, 5, 32767));
        add_typed(mk(OP_HQUERY, 0, 5, 0), 524272, 65535, 1'b0);
        reqs.push_back(mk(OP_HBIAS, 0, 6, -32768));
        add_typed(mk(OP_HQUERY, 0, 6, 0), -524288, 0, 1'b0);
        reqs.push_back(mk(OP_HBIAS, 0, 7, 0));
        add_typed(mk(OP_HQUERY, 0, 7, 0), 0, 32768, 1'b0);
        reqs.push_back(mk(OP_HBIAS, 0, 8, -4096));
        reqs.push_back(mk(OP_HQUERY, 0, 8, 0));
        // Zero inverse variance raises the error flag.
        reqs.push_back(mk(OP_VBIAS, 3, 0, 4096));
        reqs.push_back(mk(OP_INVVAR, 3, 0, 0));
        add_typed(mk(OP_VQUERY, 3, 0, 0), 65536, 0, 1'b1);
        reqs.push_back(mk(OP_VBIAS, 4, 0, -32768));
        reqs.push_back(mk(OP_INVVAR, 4, 0, 4096));
        add_typed(mk(OP_VQUERY, 4, 0, 0), -524288, -524288, 1'b0);
        // Dividing by minus one saturates the mean.
        reqs.push_back(mk(OP_INVVAR, 4, 0, -1));
        add_typed(mk(OP_VQUERY, 4, 0, 0), -524288, 32'h7fffffff, 1'b0);
        reqs.push_back(mk(OP_INVVAR, 4, 0, 1));
        reqs.push_back(mk(OP_VQUERY, 4, 0, 0));
        foreach (reqs[i]) begin
            if (reqs[i].op == OP_HBIAS) hb_ok[reqs[i].hi] = 1'b1;
            if (reqs[i].op == OP_VBIAS) vb_ok[reqs[i].vi] = 1'b1;
            if (reqs[i].op == OP_INVVAR) iv_ok[reqs[i].vi] = 1'b1;
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_counts(0, 0);
        build_directed();
        drive_all();

        // Reset-size counts, a couple of full-length queries.
        set_counts(256, 256);
        add_query(OP_HQUERY, $urandom_range(0, 255));
        add_query(OP_VQUERY, $urandom_range(0, 255));
        drive_all();

        // Counts above the array size saturate.
        set_counts(511, 300);
        add_query(OP_VQUERY, $urandom_range(0, 255));
        gen_random(30, 0);
        drive_all();

        set_counts(1, 1);
        gen_random(100, 30);
        drive_all();

        set_counts(3, 5);
        gen_random(100, 30);
        drive_all();

        for (int p = 0; p < 2; p++) begin
            set_counts($urandom_range(1, 12), $urandom_range(1, 12));
            gen_random(60, 30);
            drive_all();
        end

        $display("covered %0d loads, %0d hidden and %0d visible queries (%0d zero-variance)",
                 n_loads, n_hq, n_vq, n_flag);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", errors);
            $display("tb: failure");
        end
        $finish;
    end

endmodule
